FILE: rtl/core/osm_pkg.sv
`default_nettype none
package osm_pkg;

  localparam int CAPACITY    = 64;
  localparam int VALUE_WIDTH = 32;
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W       = $clog2(CAPACITY + 1);

  localparam logic [VALUE_WIDTH-1:0] SIGN_BIT = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  typedef enum logic [2:0] {
    REQ_INSERT = 3'd0,
    REQ_DELETE = 3'd1,
    REQ_RANK   = 3'd2,
    REQ_KTH    = 3'd3,
    REQ_PRED   = 3'd4,
    REQ_SUCC   = 3'd5
  } req_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_FULL    = 3'd1,
    ST_ABSENT  = 3'd2,
    ST_RANGE   = 3'd3,
    ST_NO_PRED = 3'd4,
    ST_NO_SUCC = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_APPLY
  } state_t;

  // broadcast from the sequencer to every cell
  typedef struct packed {
    logic                   cmp;
    logic                   ins;
    logic                   del;
    logic [VALUE_WIDTH-1:0] key;
    logic [6:0]             kth;
    logic [CNT_W-1:0]       count;
  } cell_ctl_t;

  // per-cell flags seen by neighbors and the result reduction
  typedef struct packed {
    logic lt;
    logic le;
    logic pred;
    logic succ;
    logic del;
    logic kth;
  } cell_stat_t;

  // 32-bit signed operand to order-preserving biased key
  function automatic logic [VALUE_WIDTH-1:0] key_of(input logic signed [31:0] v);
    logic signed [VALUE_WIDTH-1:0] s;
    s = VALUE_WIDTH'(v);
    return s ^ SIGN_BIT;
  endfunction

  function automatic logic [31:0] value_of(input logic [VALUE_WIDTH-1:0] k);
    logic signed [VALUE_WIDTH-1:0] s;
    s = k ^ SIGN_BIT;
    return 32'(s);
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/osm_cell.sv
`default_nettype none
module osm_cell (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic [osm_pkg::IDX_W-1:0]           idx,
  input  wire osm_pkg::cell_ctl_t                  ctl,
  input  wire logic [osm_pkg::VALUE_WIDTH-1:0]     left_val,
  input  wire logic [osm_pkg::VALUE_WIDTH-1:0]     right_val,
  input  wire logic                                prev_lt,
  input  wire logic                                prev_le,
  input  wire logic                                next_lt,
  output logic      [osm_pkg::VALUE_WIDTH-1:0]     val,
  output osm_pkg::cell_stat_t                      stat
);

  logic [osm_pkg::VALUE_WIDTH-1:0] val_r, val_nxt;
  logic                            lt_r, le_r, valid_r, kth_r;
  logic                            valid_now;

  assign valid_now = 32'(idx) < 32'(ctl.count);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lt_r    <= 1'b0;
      le_r    <= 1'b0;
      valid_r <= 1'b0;
      kth_r   <= 1'b0;
    end else if (ctl.cmp) begin
      lt_r    <= valid_now && (val_r < ctl.key);
      le_r    <= valid_now && (val_r <= ctl.key);
      valid_r <= valid_now;
      kth_r   <= valid_now && (32'(ctl.kth) == 32'(idx) + 32'd1);
    end
  end

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins && !le_r) begin
      val_nxt = prev_le ? ctl.key : left_val;
    end else if (ctl.del && !lt_r) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val       = val_r;
  assign stat.lt   = lt_r;
  assign stat.le   = le_r;
  assign stat.pred = lt_r && !next_lt;
  assign stat.succ = valid_r && !le_r && prev_le;
  assign stat.del  = le_r && !lt_r && prev_lt;
  assign stat.kth  = kth_r;

endmodule
`default_nettype wire

FILE: rtl/core/order_statistic_multiset.sv
// Ordered multiset of up to CAPACITY signed values held as a sorted row of
// cells, one value per cell. Requests enter on the in_ channel (req_type in
// in_tuser) and each gives exactly one result on the out_ channel. A request
// passes through accept, a compare cycle in which every cell compares its value
// with the operand, and an apply cycle in which the row shifts by one place for
// insert or delete and the result is registered, held while the last result is
// not yet taken. The next request is taken in the cycle after the apply, also
// while a result still waits. Reset empties the set; no clearing pass is needed.
`default_nettype none
module order_statistic_multiset (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // value[31:0], kth_index[38:32], zero pad
  input  wire logic [2:0]  in_tuser,   // req_type[2:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic      [55:0] out_tdata   // result_value[31:0], rank_out[38:32],
                                       // status[41:39], count_out[48:42], zero pad
);

  localparam int CAP = osm_pkg::CAPACITY;
  localparam int VW  = osm_pkg::VALUE_WIDTH;
  localparam int CW  = osm_pkg::CNT_W;

  osm_pkg::state_t state_r, state_nxt;
  logic [2:0]      req_r;
  logic [VW-1:0]   key_r;
  logic [6:0]      kth_r;
  logic [CW-1:0]   count_r, count_nxt;
  logic            out_tvalid_r;
  logic [55:0]     out_tdata_r, out_tdata_nxt;

  logic in_xfer, cmp_en, commit;

  osm_pkg::cell_ctl_t  ctl;
  logic [VW-1:0]       cval [CAP];
  osm_pkg::cell_stat_t cstat [CAP];

  logic [VW-1:0] pred_val, succ_val, kth_val;
  logic          found, any_succ, any_kth;
  logic [CW-1:0] lo;
  logic          ins_ok;

  assign in_xfer = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      osm_pkg::S_IDLE:  if (in_tvalid) state_nxt = osm_pkg::S_CMP;
      osm_pkg::S_CMP:   state_nxt = osm_pkg::S_APPLY;
      osm_pkg::S_APPLY: if (!out_tvalid_r || out_tready) state_nxt = osm_pkg::S_IDLE;
      default:          state_nxt = osm_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_tready = 1'b0;
    cmp_en    = 1'b0;
    commit    = 1'b0;
    case (state_r)
      osm_pkg::S_IDLE:  in_tready = 1'b1;
      osm_pkg::S_CMP:   cmp_en = 1'b1;
      osm_pkg::S_APPLY: commit = !out_tvalid_r || out_tready;
      default:          ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= osm_pkg::S_IDLE;
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (commit) begin
        count_r      <= count_nxt;
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_r <= in_tuser;
      key_r <= osm_pkg::key_of(in_tdata[31:0]);
      kth_r <= in_tdata[38:32];
    end
    if (commit) begin
      out_tdata_r <= out_tdata_nxt;
    end
  end

  assign ins_ok = 32'(count_r) < 32'(CAP);

  always_comb begin
    ctl.cmp   = cmp_en;
    ctl.ins   = commit && (req_r == osm_pkg::REQ_INSERT) && ins_ok;
    ctl.del   = commit && (req_r == osm_pkg::REQ_DELETE) && found;
    ctl.key   = key_r;
    ctl.kth   = kth_r;
    ctl.count = count_r;
  end

  for (genvar i = 0; i < CAP; i++) begin : g_cell
    osm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .idx       (osm_pkg::IDX_W'(i)),
      .ctl       (ctl),
      .left_val  ((i == 0) ? key_r : cval[(i == 0) ? 0 : i - 1]),
      .right_val (cval[(i == CAP - 1) ? i : i + 1]),
      .prev_lt   ((i == 0) ? 1'b1 : cstat[(i == 0) ? 0 : i - 1].lt),
      .prev_le   ((i == 0) ? 1'b1 : cstat[(i == 0) ? 0 : i - 1].le),
      .next_lt   ((i == CAP - 1) ? 1'b0 : cstat[(i == CAP - 1) ? i : i + 1].lt),
      .val       (cval[i]),
      .stat      (cstat[i])
    );
  end

  // one-hot selects from the row, reduced by AND-OR
  always_comb begin
    pred_val = '0;
    succ_val = '0;
    kth_val  = '0;
    found    = 1'b0;
    any_succ = 1'b0;
    any_kth  = 1'b0;
    lo       = '0;
    for (int i = 0; i < CAP; i++) begin
      if (cstat[i].pred) begin
        pred_val = pred_val | cval[i];
        lo       = lo | CW'(i + 1);
      end
      if (cstat[i].succ) succ_val = succ_val | cval[i];
      if (cstat[i].kth)  kth_val  = kth_val | cval[i];
      found    = found | cstat[i].del;
      any_succ = any_succ | cstat[i].succ;
      any_kth  = any_kth | cstat[i].kth;
    end
  end

  always_comb begin
    logic [31:0]      res;
    logic [6:0]       rank;
    osm_pkg::status_t st;
    res       = '0;
    rank      = '0;
    st        = osm_pkg::ST_OK;
    count_nxt = count_r;
    case (req_r)
      osm_pkg::REQ_INSERT: begin
        if (ins_ok) count_nxt = count_r + CW'(1);
        else        st = osm_pkg::ST_FULL;
      end
      osm_pkg::REQ_DELETE: begin
        if (found) count_nxt = count_r - CW'(1);
        else       st = osm_pkg::ST_ABSENT;
      end
      osm_pkg::REQ_RANK: rank = 7'(32'(lo) + 32'd1);
      osm_pkg::REQ_KTH: begin
        if (any_kth) res = osm_pkg::value_of(kth_val);
        else         st = osm_pkg::ST_RANGE;
      end
      osm_pkg::REQ_PRED: begin
        if (cstat[0].lt) res = osm_pkg::value_of(pred_val);
        else             st = osm_pkg::ST_NO_PRED;
      end
      osm_pkg::REQ_SUCC: begin
        if (any_succ) res = osm_pkg::value_of(succ_val);
        else          st = osm_pkg::ST_NO_SUCC;
      end
      default: ;
    endcase
    out_tdata_nxt = {7'd0, 7'(count_nxt), st, rank, res};
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;

endmodule
`default_nettype wire
